FILE: rtl/core/gf128_multiply_accumulate_top_defines.svh
`ifndef GF128_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH
`define GF128_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH

// same-cycle implication
`define GFMAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gf128mac_pkg.sv
package gf128mac_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned POLY_W = 8;
    localparam logic [POLY_W-1:0] FEEDBACK_POLY = 8'h87;

    localparam logic [2:0] OP_MUL      = 3'd0;
    localparam logic [2:0] OP_MUL_ADD  = 3'd1;
    localparam logic [2:0] OP_SQUARE   = 3'd2;
    localparam logic [2:0] OP_UNRED_MA = 3'd3;
    localparam logic [2:0] OP_REDUCE   = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] a_w0;
        logic [63:0] a_w1;
        logic [63:0] b_w0;
        logic [63:0] b_w1;
        logic [63:0] acc_w0;
        logic [63:0] acc_w1;
        logic [63:0] acc_w2;
        logic [63:0] acc_w3;
    } t_in_word;

    typedef struct packed {
        logic [63:0] res_w0;
        logic [63:0] res_w1;
        logic [63:0] res_w2;
        logic [63:0] res_w3;
    } t_out_word;

    // carry-less 64x64 -> 128
    function automatic logic [127:0] clmul64(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] acc;
        acc = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (y[i]) begin
                acc = acc ^ ({64'b0, x} << i);
            end
        end
        return acc;
    endfunction

    // x times the feedback constant, 128-bit carry-less
    function automatic logic [127:0] fold64(input logic [63:0] x);
        logic [127:0] acc;
        acc = '0;
        for (int i = 0; i < POLY_W; i++) begin
            if (FEEDBACK_POLY[i]) begin
                acc = acc ^ ({64'b0, x} << i);
            end
        end
        return acc;
    endfunction

    // 256 -> 128 modulo x^128+x^7+x^2+x+1
    function automatic logic [127:0] reduce256(input logic [255:0] v);
        logic [127:0] h;
        logic [127:0] f;
        logic [63:0]  w2;
        logic [63:0]  r0;
        logic [63:0]  r1;
        h  = fold64(v[255:192]);
        r1 = v[127:64] ^ h[63:0];
        w2 = v[191:128] ^ h[127:64];
        f  = fold64(w2);
        r0 = v[63:0] ^ f[63:0];
        r1 = r1 ^ f[127:64];
        return {r1, r0};
    endfunction

endpackage

FILE: rtl/core/gf128_multiply_accumulate_top.sv
// GF(2^128) multiply-accumulate, polynomial x^128+x^7+x^2+x+1, word 0 holds
// coefficients 0..63. Takes one word per cycle unless stalled and returns one
// result word per input: stage 1 forms the four 64x64 carry-less partial
// products, stage 2 merges them with the accumulator, stage 3 folds the
// 256-bit value down and holds the output. Ready ripples back through the
// three stage valids, so a stalled output only blocks once every stage is full.
`include "gf128_multiply_accumulate_top_defines.svh"

module gf128_multiply_accumulate_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  gf128mac_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output gf128mac_pkg::t_out_word o_out_data
);

    logic ready1, ready2, ready3;

    // stage 1
    logic         r_v1;
    logic [2:0]   r_op1;
    logic [127:0] r_p00, r_p01, r_p10, r_p11;
    logic [255:0] r_acc1;
    logic [63:0]  b0_sel, b1_sel;
    logic [127:0] n_p00, n_p01, n_p10, n_p11;

    // stage 2
    logic         r_v2;
    logic         r_unred2;
    logic [255:0] r_val2;
    logic [127:0] r_add2;
    logic         n_unred2;
    logic [255:0] n_val2;
    logic [127:0] n_add2;
    logic [255:0] prod;

    // stage 3
    logic         r_v3;
    logic         r_unred3;
    gf128mac_pkg::t_out_word r_out3;
    gf128mac_pkg::t_out_word n_out3;
    logic [127:0] red;

    assign ready3     = !r_v3 || i_out_ready;
    assign ready2     = !r_v2 || ready3;
    assign ready1     = !r_v1 || ready2;
    assign o_in_ready = ready1;

    always_comb begin
        if (i_in_data.operation == gf128mac_pkg::OP_SQUARE) begin
            b0_sel = i_in_data.a_w0;
            b1_sel = i_in_data.a_w1;
        end else begin
            b0_sel = i_in_data.b_w0;
            b1_sel = i_in_data.b_w1;
        end
        n_p00 = gf128mac_pkg::clmul64(i_in_data.a_w0, b0_sel);
        n_p01 = gf128mac_pkg::clmul64(i_in_data.a_w0, b1_sel);
        n_p10 = gf128mac_pkg::clmul64(i_in_data.a_w1, b0_sel);
        n_p11 = gf128mac_pkg::clmul64(i_in_data.a_w1, b1_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_in_valid) begin
            r_op1  <= i_in_data.operation;
            r_p00  <= n_p00;
            r_p01  <= n_p01;
            r_p10  <= n_p10;
            r_p11  <= n_p11;
            r_acc1 <= {i_in_data.acc_w3, i_in_data.acc_w2,
                       i_in_data.acc_w1, i_in_data.acc_w0};
        end
    end

    assign prod = {r_p11, r_p00} ^ {64'b0, (r_p01 ^ r_p10), 64'b0};

    always_comb begin
        n_unred2 = 1'b0;
        n_val2   = '0;
        n_add2   = '0;
        unique case (r_op1) inside
            gf128mac_pkg::OP_MUL, gf128mac_pkg::OP_SQUARE: begin
                n_val2 = prod;
            end
            gf128mac_pkg::OP_MUL_ADD: begin
                n_val2 = prod;
                n_add2 = r_acc1[127:0];
            end
            gf128mac_pkg::OP_UNRED_MA: begin
                n_val2   = prod ^ r_acc1;
                n_unred2 = 1'b1;
            end
            gf128mac_pkg::OP_REDUCE: begin
                n_val2 = r_acc1;
            end
            default: begin
                n_val2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_unred2 <= n_unred2;
            r_val2   <= n_val2;
            r_add2   <= n_add2;
        end
    end

    assign red = gf128mac_pkg::reduce256(r_val2) ^ r_add2;

    always_comb begin
        if (r_unred2) begin
            n_out3.res_w0 = r_val2[63:0];
            n_out3.res_w1 = r_val2[127:64];
            n_out3.res_w2 = r_val2[191:128];
            n_out3.res_w3 = r_val2[255:192];
        end else begin
            n_out3.res_w0 = red[63:0];
            n_out3.res_w1 = red[127:64];
            n_out3.res_w2 = '0;
            n_out3.res_w3 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r_v2) begin
            r_out3   <= n_out3;
            r_unred3 <= r_unred2;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out3;

    `GFMAC_ASSERT_NOW(a_reduced_upper_zero, i_clk, i_rst_n,
        o_out_valid && !r_unred3,
        o_out_data.res_w2 == 64'd0 && o_out_data.res_w3 == 64'd0,
        "reduced result has nonzero upper words")
    `GFMAC_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_v1,
        "accepted word did not reach stage 1")
    `GFMAC_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n,
        r_v1 && !ready2, r_v1 && $stable(r_op1) && $stable(r_p00),
        "stage 1 changed while stalled")
    `GFMAC_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n,
        i_out_ready, o_in_ready,
        "input stalled while output drains")

endmodule

FILE: sim/tb_gf128_multiply_accumulate_top.sv
module tb_gf128_multiply_accumulate_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;
    localparam int RANDOM_WORDS   = 550;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [127:0] ONES128 = '1;
    localparam logic [255:0] ONES256 = '1;
    localparam logic [127:0] TOP128  = 128'd1 << 127;

    class gf_result_board;
        gf128mac_pkg::t_out_word expected_q[$];
        int errors;
        int shown;

        static function logic [255:0] clmul128(logic [127:0] x, logic [127:0] y);
            logic [255:0] p;
            p = '0;
            for (int i = 0; i < 128; i++) begin
                if (y[i]) begin
                    p ^= {128'b0, x} << i;
                end
            end
            return p;
        endfunction

        // bit-serial fold from the top coefficient down
        static function logic [127:0] fold256(logic [255:0] v);
            logic [255:0] m;
            m = (256'd1 << 128) | 256'(gf128mac_pkg::FEEDBACK_POLY);
            for (int i = 255; i >= 128; i--) begin
                if (v[i]) begin
                    v ^= m << (i - 128);
                end
            end
            return v[127:0];
        endfunction

        static function gf128mac_pkg::t_out_word predict(gf128mac_pkg::t_in_word w);
            logic [127:0] a;
            logic [127:0] b;
            logic [255:0] acc;
            logic [255:0] full;
            gf128mac_pkg::t_out_word r;
            a    = {w.a_w1, w.a_w0};
            b    = {w.b_w1, w.b_w0};
            acc  = {w.acc_w3, w.acc_w2, w.acc_w1, w.acc_w0};
            full = '0;
            case (w.operation)
                gf128mac_pkg::OP_MUL: begin
                    full[127:0] = fold256(clmul128(a, b));
                end
                gf128mac_pkg::OP_MUL_ADD: begin
                    full[127:0] = fold256(clmul128(a, b)) ^ acc[127:0];
                end
                gf128mac_pkg::OP_SQUARE: begin
                    full[127:0] = fold256(clmul128(a, a));
                end
                gf128mac_pkg::OP_UNRED_MA: begin
                    full = clmul128(a, b) ^ acc;
                end
                gf128mac_pkg::OP_REDUCE: begin
                    full[127:0] = fold256(acc);
                end
                default: begin
                    full = '0;
                end
            endcase
            r.res_w0 = full[63:0];
            r.res_w1 = full[127:64];
            r.res_w2 = full[191:128];
            r.res_w3 = full[255:192];
            return r;
        endfunction

        function void flag(string msg);
            errors++;
            if (shown < 10) begin
                shown++;
                $display("%s", msg);
            end
        endfunction

        function void note_operand(gf128mac_pkg::t_in_word w);
            expected_q.push_back(predict(w));
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (got_v !== exp_v) begin
                flag($sformatf("mismatch %s: expected %h got %h", name, exp_v, got_v));
            end
        endfunction

        function void check_result(gf128mac_pkg::t_out_word got);
            gf128mac_pkg::t_out_word exp_w;
            if (expected_q.size() == 0) begin
                flag($sformatf("result word with nothing pending: %h", got));
                return;
            end
            exp_w = expected_q.pop_front();
            compare_field("res_w0", exp_w.res_w0, got.res_w0);
            compare_field("res_w1", exp_w.res_w1, got.res_w1);
            compare_field("res_w2", exp_w.res_w2, got.res_w2);
            compare_field("res_w3", exp_w.res_w3, got.res_w3);
        endfunction
    endclass

    typedef enum logic [1:0] {RX_FREE, RX_HOLD, RX_FLICKER} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    gf128mac_pkg::t_in_word  in_data = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    gf128mac_pkg::t_out_word o_out_data;

    gf_result_board board;
    gf128mac_pkg::t_in_word stim_q[$];
    int             idle_cycles = 0;
    t_rx_mode       rx_mode = RX_FREE;
    int             rx_left = 0;
    int             rx_pick;

    gf128_multiply_accumulate_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: runs of free flow, hard stalls and random flicker
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pick = $urandom_range(0, 9);
            if (rx_pick < 4) begin
                rx_mode = RX_FREE;
                rx_left = $urandom_range(1, 40);
            end else if (rx_pick < 7) begin
                rx_mode = RX_HOLD;
                rx_left = $urandom_range(1, 12);
            end else begin
                rx_mode = RX_FLICKER;
                rx_left = $urandom_range(1, 20);
            end
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  out_ready <= 1'b1;
            RX_HOLD:  out_ready <= 1'b0;
            default:  out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                board.note_operand(in_data);
            end
            if (o_out_valid && out_ready) begin
                board.check_result(o_out_data);
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    function automatic gf128mac_pkg::t_in_word make_word(logic [2:0] op, logic [127:0] a,
                                                         logic [127:0] b, logic [255:0] acc);
        gf128mac_pkg::t_in_word w;
        w.operation = op;
        w.a_w0   = a[63:0];
        w.a_w1   = a[127:64];
        w.b_w0   = b[63:0];
        w.b_w1   = b[127:64];
        w.acc_w0 = acc[63:0];
        w.acc_w1 = acc[127:64];
        w.acc_w2 = acc[191:128];
        w.acc_w3 = acc[255:192];
        return w;
    endfunction

    function automatic logic [63:0] rand_lane();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [127:0] rand_128();
        return {rand_lane(), rand_lane()};
    endfunction

    function automatic logic [2:0] rand_op();
        if ($urandom_range(0, 19) == 0) begin
            return 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        end
        return 3'($urandom_range(gf128mac_pkg::OP_MUL, gf128mac_pkg::OP_REDUCE));
    endfunction

    task automatic push_word(input gf128mac_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int burst;
        board = new;

        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL, '0, '0, '0));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL, ONES128, ONES128, ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL, 128'd1, rand_128(), ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL, TOP128, TOP128, '0));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL_ADD, ONES128, ONES128, ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL_ADD, '0, rand_128(),
                                   {rand_128(), rand_128()}));
        stim_q.push_back(make_word(gf128mac_pkg::OP_MUL_ADD, TOP128, TOP128,
                                   {ONES128, 128'd0}));
        stim_q.push_back(make_word(gf128mac_pkg::OP_SQUARE, ONES128, rand_128(), ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_SQUARE, TOP128, ONES128, '0));
        stim_q.push_back(make_word(gf128mac_pkg::OP_SQUARE, '0, ONES128, ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_UNRED_MA, ONES128, ONES128, ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_UNRED_MA, TOP128, TOP128, '0));
        stim_q.push_back(make_word(gf128mac_pkg::OP_UNRED_MA, '0, ONES128,
                                   {rand_128(), rand_128()}));
        stim_q.push_back(make_word(gf128mac_pkg::OP_REDUCE, ONES128, ONES128, ONES256));
        stim_q.push_back(make_word(gf128mac_pkg::OP_REDUCE, rand_128(), rand_128(),
                                   {64'hFFFF_FFFF_FFFF_FFFF, 192'd0}));
        stim_q.push_back(make_word(gf128mac_pkg::OP_REDUCE, '0, '0, 256'd1 << 255));
        stim_q.push_back(make_word(gf128mac_pkg::OP_REDUCE, '0, '0, 256'd1 << 128));
        stim_q.push_back(make_word(gf128mac_pkg::OP_REDUCE, '0, '0, {128'd0, ONES128}));
        for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++) begin
            stim_q.push_back(make_word(3'(op), ONES128, ONES128, ONES256));
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            stim_q.push_back(make_word(rand_op(), rand_128(), rand_128(),
                                       {rand_128(), rand_128()}));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (stim_q.size() != 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100)
                                                : $urandom_range(1, 30);
            while (burst > 0 && stim_q.size() != 0) begin
                push_word(stim_q.pop_front());
                burst--;
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end

        while (board.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.expected_q.size() != 0) begin
            board.flag($sformatf("%0d result words never arrived", board.expected_q.size()));
        end

        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gf128mac_pkg.sv
rtl/core/gf128_multiply_accumulate_top.sv
sim/tb_gf128_multiply_accumulate_top.sv
